/* src/sorted_alarm_table_macros.svh */
// ----------------------------------------------------------------------------
// Sorted alarm table assertion macros
// Shared concurrent assertion forms, clocked on rising edge, reset low.
// ----------------------------------------------------------------------------
`ifndef SORTED_ALARM_TABLE_MACROS_SVH
`define SORTED_ALARM_TABLE_MACROS_SVH

// same-cycle implication
`define SAT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted alarm table: same-cycle check failed");

// next-cycle implication
`define SAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted alarm table: next-cycle check failed");

`endif

/* src/sat_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted alarm table package
// Beat types, slot layout, sizing constants, codes and the slot match unit.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int MaxEntries = 8;
  localparam int AddrW      = $clog2(MaxEntries);
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int CmpW       = (CntW > 3) ? CntW : 3;
  localparam int SlotW      = 64;

  typedef enum logic [2:0] {
    ActAdd        = 3'd0,
    ActCancelTime = 3'd1,
    ActCancelKind = 3'd2,
    ActFire       = 3'd3,
    ActRead       = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StNone  = 2'd2,
    StRange = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SqIdle,
    SqAddShift,
    SqAddPlace,
    SqScan,
    SqShift,
    SqReadWait,
    SqResp
  } seq_state_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] event_time;
    logic        timer_flag;
    logic [30:0] alarm_id;
    logic [2:0]  entry_index;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] entry_time;
    logic        entry_kind;
    logic [30:0] entry_id;
    logic [3:0]  entry_count;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] tstamp;
    logic        kind;
    logic [30:0] id;
  } slot_t;

  function automatic logic slot_match(action_e act, slot_t s, in_beat_t req);
    logic hit;
    hit = 1'b0;
    unique case (act)
      ActCancelTime: hit = (s.tstamp == req.event_time);
      ActCancelKind: hit = (s.kind == req.timer_flag);
      ActFire:       hit = (s.id == req.alarm_id);
      default:       hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

/* src/sorted_alarm_table.sv */
// ----------------------------------------------------------------------------
// Sorted alarm table
// Bounded list of pending alarms held in ascending time order in a slot RAM.
// ----------------------------------------------------------------------------
// A request beat is taken only while the sequencer is idle; it then walks the
// slot RAM one slot per cycle through its single read and single write port.
// Full adds, requests on an empty table, out-of-range reads and unknown actions
// go straight to the result register; a read first waits for the registered
// RAM read data; an add moves each later entry up one slot, then places the
// new one; a cancel or fire scans slots in order and moves the entries after
// a match down one slot. Each may then wait for the result register to empty.
// A new request is taken while the previous result still waits to be taken.
`include "sorted_alarm_table_macros.svh"

module sorted_alarm_table
  import sat_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  seq_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  in_beat_t  req_q, req_d;
  out_beat_t res_q, res_d;
  out_beat_t out_q, out_d;
  logic      out_valid_q, out_valid_d;

  logic             rd_en, wr_en;
  logic [AddrW-1:0] rd_addr, wr_addr;
  slot_t            wr_data, rd_slot;
  logic [SlotW-1:0] rd_raw;

  logic      in_fire;
  action_e   in_act, req_act;
  slot_t     in_slot, req_slot;
  logic      hit;
  logic [CntW-1:0] ptr_p1, ptr_p2;

  sat_ram #(
    .Width (SlotW),
    .Depth (MaxEntries)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_raw)
  );

  assign rd_slot  = slot_t'(rd_raw);
  assign in_fire  = in_valid_i && in_ready_o;
  assign in_act   = action_e'(in_data_i.action);
  assign req_act  = action_e'(req_q.action);
  assign in_slot  = '{tstamp: in_data_i.event_time, kind: in_data_i.timer_flag,
                      id: in_data_i.alarm_id};
  assign req_slot = '{tstamp: req_q.event_time, kind: req_q.timer_flag,
                      id: req_q.alarm_id};
  assign hit      = slot_match(req_act, rd_slot, req_q);
  assign ptr_p1   = ptr_q + CntW'(1);
  assign ptr_p2   = ptr_q + CntW'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SqIdle;
      cnt_q       <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = req_slot;

    unique case (state_q)
      SqIdle: begin
        if (in_fire) begin
          req_d = in_data_i;
          res_d = '0;
          state_d = SqResp;
          unique case (in_act)
            ActAdd: begin
              if (cnt_q == CntW'(MaxEntries)) begin
                res_d.status = StFull;
              end else if (cnt_q == '0) begin
                wr_en   = 1'b1;
                wr_data = in_slot;
                cnt_d   = CntW'(1);
                res_d.status = StOk;
              end else begin
                rd_en   = 1'b1;
                rd_addr = AddrW'(cnt_q - CntW'(1));
                ptr_d   = cnt_q;
                state_d = SqAddShift;
              end
            end
            ActCancelTime, ActCancelKind, ActFire: begin
              if (cnt_q == '0) begin
                res_d.status = StNone;
              end else begin
                rd_en   = 1'b1;
                ptr_d   = '0;
                state_d = SqScan;
              end
            end
            ActRead: begin
              if (CmpW'(in_data_i.entry_index) < CmpW'(cnt_q)) begin
                rd_en   = 1'b1;
                rd_addr = AddrW'(in_data_i.entry_index);
                state_d = SqReadWait;
              end else begin
                res_d.status = StRange;
              end
            end
            default: begin
              res_d.status = StNone;
            end
          endcase
        end
      end

      SqAddShift: begin
        wr_en   = 1'b1;
        wr_addr = AddrW'(ptr_q);
        if (rd_slot.tstamp >= req_q.event_time) begin
          wr_data = rd_slot;
          ptr_d   = ptr_q - CntW'(1);
          if (ptr_q == CntW'(1)) begin
            state_d = SqAddPlace;
          end else begin
            rd_en   = 1'b1;
            rd_addr = AddrW'(ptr_q - CntW'(2));
          end
        end else begin
          wr_data = req_slot;
          cnt_d   = cnt_q + CntW'(1);
          res_d.status = StOk;
          state_d = SqResp;
        end
      end

      SqAddPlace: begin
        wr_en   = 1'b1;
        wr_addr = AddrW'(ptr_q);
        wr_data = req_slot;
        cnt_d   = cnt_q + CntW'(1);
        res_d.status = StOk;
        state_d = SqResp;
      end

      SqScan: begin
        if (ptr_p1 < cnt_q) begin
          rd_en   = 1'b1;
          rd_addr = AddrW'(ptr_p1);
        end
        if (hit) begin
          res_d.status     = StOk;
          res_d.entry_time = rd_slot.tstamp;
          res_d.entry_kind = rd_slot.kind;
          res_d.entry_id   = rd_slot.id;
          if (ptr_p1 == cnt_q) begin
            cnt_d   = cnt_q - CntW'(1);
            state_d = SqResp;
          end else begin
            state_d = SqShift;
          end
        end else if (ptr_p1 == cnt_q) begin
          res_d.status = StNone;
          state_d = SqResp;
        end else begin
          ptr_d = ptr_p1;
        end
      end

      SqShift: begin
        wr_en   = 1'b1;
        wr_addr = AddrW'(ptr_q);
        wr_data = rd_slot;
        ptr_d   = ptr_p1;
        if (ptr_p2 < cnt_q) begin
          rd_en   = 1'b1;
          rd_addr = AddrW'(ptr_p2);
        end else begin
          cnt_d   = cnt_q - CntW'(1);
          state_d = SqResp;
        end
      end

      SqReadWait: begin
        res_d.status     = StOk;
        res_d.entry_time = rd_slot.tstamp;
        res_d.entry_kind = rd_slot.kind;
        res_d.entry_id   = rd_slot.id;
        state_d = SqResp;
      end

      SqResp: begin
        if (!out_valid_q || out_ready_i) begin
          out_d             = res_q;
          out_d.entry_count = 4'(cnt_q);
          out_valid_d       = 1'b1;
          state_d           = SqIdle;
        end
      end

      default: begin
        state_d = SqIdle;
      end
    endcase
  end

  assign in_ready_o  = (state_q == SqIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SAT_ASSERT_IMPLY(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(MaxEntries))
  `SAT_ASSERT_IMPLY(a_no_idle_write, clk_i, rst_ni, state_q == SqIdle && !in_fire, !wr_en)
  `SAT_ASSERT_NEXT(a_full_add, clk_i, rst_ni, in_fire && in_act == ActAdd && cnt_q == CntW'(MaxEntries), state_q == SqResp && res_q.status == StFull)

endmodule

/* src/sat_ram.sv */
// ----------------------------------------------------------------------------
// Sorted alarm table slot RAM
// Generic one-write, one-read memory with registered read data.
// ----------------------------------------------------------------------------
module sat_ram #(
  parameter int Width = 64,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
